// ===== sv/opcq_pkg.sv =====
`default_nettype none

package opcq_pkg;

   // fixed field widths
   localparam int CH_W        = 8;
   localparam int COLOR_W     = 3 * CH_W;
   localparam int INDEX_W     = 12;
   localparam int COUNT_W     = 13;
   localparam int DEPTH_REG_W = 3;
   localparam int DEPTH_W     = 4;

   // request mode codes
   localparam logic [1:0] MODE_INSERT  = 2'd0;
   localparam logic [1:0] MODE_MAP     = 2'd1;
   localparam logic [1:0] MODE_PALETTE = 2'd2;

   // fixed colours and the black/white palette
   localparam logic [COLOR_W-1:0] COLOR_WHITE   = {COLOR_W{1'b1}};
   localparam logic [COLOR_W-1:0] COLOR_BLACK   = '0;
   localparam logic [INDEX_W-1:0] PAL_WHITE_IDX = 12'd0;
   localparam logic [INDEX_W-1:0] PAL_BLACK_IDX = 12'd1;
   localparam logic [COUNT_W-1:0] BW_COUNT      = 13'd2;

   // work kinds passed from front to back
   typedef enum logic [1:0] {
      OP_INSERT,
      OP_MAP,
      OP_PALETTE,
      OP_DIRECT
   } op_kind_type;

   // one queued command
   typedef struct packed {
      op_kind_type          kind;
      logic [COLOR_W-1:0]   color;
      logic [INDEX_W-1:0]   palette_index;
      logic                 hit_fixed;
      logic                 count_fixed;
   } cmd_type;

   // back end sequencer
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_ORDER,
      ST_FETCH,
      ST_EMIT
   } back_state_type;

endpackage

`default_nettype wire

// ===== sv/octree_prefix_color_quantizer.sv =====
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    mode, red, green, blue, palette_index
// rsp       out        rsp_valid/rsp_ready    out_red, out_green, out_blue, hit, entry_count
// csr       in         csr_wr_en              csr_wr_data (depth)
//
// the back sequencer takes a word only in idle and returns there once its result is
// loaded; a map or insert word passes the lookup state, an in-range palette read the
// order list then the colour store, and any other word goes straight to emit.
// reset and every depth write start a sweep over the valid store, during which req_ready
// is low; reset is synchronous, active high.
// a held result stalls the back, the two-word queue behind it fills, then req_ready drops.
`default_nettype none

module octree_prefix_color_quantizer #(
   parameter int MAX_DEPTH = 4
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [opcq_pkg::DEPTH_REG_W-1:0]      csr_wr_data,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [1:0]                            req_mode,
   input  wire logic [opcq_pkg::CH_W-1:0]             req_red,
   input  wire logic [opcq_pkg::CH_W-1:0]             req_green,
   input  wire logic [opcq_pkg::CH_W-1:0]             req_blue,
   input  wire logic [opcq_pkg::INDEX_W-1:0]          req_palette_index,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [opcq_pkg::CH_W-1:0]                  rsp_out_red,
   output logic [opcq_pkg::CH_W-1:0]                  rsp_out_green,
   output logic [opcq_pkg::CH_W-1:0]                  rsp_out_blue,
   output logic                                       rsp_hit,
   output logic [opcq_pkg::COUNT_W-1:0]               rsp_entry_count
);

   localparam int AW     = 3 * MAX_DEPTH;
   localparam int CMD_W  = $bits(opcq_pkg::cmd_type);
   localparam int DATA_W = CMD_W + AW;

   logic                 clearing;
   logic                 fq_valid;
   logic                 fq_ready;
   opcq_pkg::cmd_type    fq_cmd;
   logic [AW-1:0]        fq_addr;
   logic                 bq_valid;
   logic                 bq_ready;
   logic [DATA_W-1:0]    bq_data;
   opcq_pkg::cmd_type    bq_cmd;

   // classify and address
   opcq_front #(
      .MAX_DEPTH(MAX_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_palette_index(req_palette_index),
      .clearing         (clearing),
      .q_valid          (fq_valid),
      .q_ready          (fq_ready),
      .q_cmd            (fq_cmd),
      .q_addr           (fq_addr)
   );

   // command queue
   opcq_queue #(
      .DATA_W(DATA_W)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_valid(fq_valid),
      .wr_ready(fq_ready),
      .wr_data ({fq_addr, fq_cmd}),
      .rd_valid(bq_valid),
      .rd_ready(bq_ready),
      .rd_data (bq_data)
   );

   assign bq_cmd = opcq_pkg::cmd_type'(bq_data[CMD_W-1:0]);

   // tables and result register
   opcq_back #(
      .MAX_DEPTH(MAX_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .clear_start    (csr_wr_en),
      .clearing       (clearing),
      .cmd_valid      (bq_valid),
      .cmd_ready      (bq_ready),
      .cmd            (bq_cmd),
      .cmd_addr       (bq_data[DATA_W-1:CMD_W]),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_hit        (rsp_hit),
      .rsp_entry_count(rsp_entry_count)
   );

endmodule

`default_nettype wire

// ===== sv/opcq_front.sv =====
`default_nettype none

module opcq_front #(
   parameter int MAX_DEPTH = 4
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [opcq_pkg::DEPTH_REG_W-1:0]      csr_wr_data,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [1:0]                            req_mode,
   input  wire logic [opcq_pkg::CH_W-1:0]             req_red,
   input  wire logic [opcq_pkg::CH_W-1:0]             req_green,
   input  wire logic [opcq_pkg::CH_W-1:0]             req_blue,
   input  wire logic [opcq_pkg::INDEX_W-1:0]          req_palette_index,
   input  wire logic                                  clearing,
   output logic                                       q_valid,
   input  wire logic                                  q_ready,
   output opcq_pkg::cmd_type                          q_cmd,
   output logic [3*MAX_DEPTH-1:0]                     q_addr
);

   localparam int AW = 3 * MAX_DEPTH;

   logic [opcq_pkg::DEPTH_W-1:0] depth_ff;
   logic [opcq_pkg::DEPTH_W-1:0] depth_in;
   logic [opcq_pkg::DEPTH_W-1:0] act_depth;
   logic [opcq_pkg::DEPTH_W-1:0] depth_gap;
   logic [4:0]                   shift;
   logic [AW-1:0]                full_addr;
   logic [opcq_pkg::COLOR_W-1:0] pixel;

   // depth register, saturated on use
   always_comb begin
      depth_in = depth_ff;
      if (csr_wr_en) begin
         depth_in = opcq_pkg::DEPTH_W'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= opcq_pkg::DEPTH_W'(MAX_DEPTH);
      end else begin
         depth_ff <= depth_in;
      end
   end

   assign act_depth = (depth_ff > opcq_pkg::DEPTH_W'(MAX_DEPTH))
                      ? opcq_pkg::DEPTH_W'(MAX_DEPTH) : depth_ff;

   // interleave r, g, b msbs at full depth, then drop unused levels
   always_comb begin
      full_addr = '0;
      for (int lvl = 0; lvl < MAX_DEPTH; lvl++) begin
         full_addr[AW-1-3*lvl] = req_red[opcq_pkg::CH_W-1-lvl];
         full_addr[AW-2-3*lvl] = req_green[opcq_pkg::CH_W-1-lvl];
         full_addr[AW-3-3*lvl] = req_blue[opcq_pkg::CH_W-1-lvl];
      end
   end

   assign depth_gap = opcq_pkg::DEPTH_W'(MAX_DEPTH) - act_depth;
   assign shift     = 5'({depth_gap, 1'b0}) + 5'(depth_gap);
   assign q_addr    = full_addr >> shift;
   assign pixel     = {req_red, req_green, req_blue};

   // handshake, held off during the clearing pass
   assign req_ready = q_ready && !clearing;
   assign q_valid   = req_valid && !clearing;

   // classify the word
   always_comb begin
      q_cmd.kind          = opcq_pkg::OP_DIRECT;
      q_cmd.color         = opcq_pkg::COLOR_BLACK;
      q_cmd.palette_index = req_palette_index;
      q_cmd.hit_fixed     = 1'b0;
      q_cmd.count_fixed   = 1'b0;
      if (act_depth == '0) begin
         q_cmd.count_fixed = 1'b1;
         unique case (req_mode)
            opcq_pkg::MODE_INSERT: begin
               q_cmd.hit_fixed = 1'b1;
            end
            opcq_pkg::MODE_MAP: begin
               q_cmd.hit_fixed = 1'b1;
               if (req_red[opcq_pkg::CH_W-1] || req_green[opcq_pkg::CH_W-1]
                   || req_blue[opcq_pkg::CH_W-1]) begin
                  q_cmd.color = opcq_pkg::COLOR_WHITE;
               end
            end
            opcq_pkg::MODE_PALETTE: begin
               if (req_palette_index == opcq_pkg::PAL_WHITE_IDX) begin
                  q_cmd.color     = opcq_pkg::COLOR_WHITE;
                  q_cmd.hit_fixed = 1'b1;
               end else if (req_palette_index == opcq_pkg::PAL_BLACK_IDX) begin
                  q_cmd.hit_fixed = 1'b1;
               end
            end
            default: begin
               q_cmd.hit_fixed = 1'b0;
            end
         endcase
      end else begin
         unique case (req_mode)
            opcq_pkg::MODE_INSERT: begin
               q_cmd.kind  = opcq_pkg::OP_INSERT;
               q_cmd.color = pixel;
            end
            opcq_pkg::MODE_MAP: begin
               q_cmd.kind = opcq_pkg::OP_MAP;
            end
            opcq_pkg::MODE_PALETTE: begin
               q_cmd.kind = opcq_pkg::OP_PALETTE;
            end
            default: begin
               q_cmd.kind = opcq_pkg::OP_DIRECT;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== sv/opcq_queue.sv =====
`default_nettype none

module opcq_queue #(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_valid,
   output logic                   wr_ready,
   input  wire logic [DATA_W-1:0] wr_data,
   output logic                   rd_valid,
   input  wire logic              rd_ready,
   output logic [DATA_W-1:0]      rd_data
);

   localparam int SLOTS = 2;

   logic [DATA_W-1:0] slot_ff [SLOTS];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        fill_ff;
   logic [1:0]        fill_in;
   logic              push;
   logic              pop;

   assign wr_ready = (fill_ff != 2'(SLOTS));
   assign rd_valid = (fill_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   // pointers and fill level
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/opcq_back.sv =====
`default_nettype none

module opcq_back #(
   parameter int MAX_DEPTH = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               clear_start,
   output logic                                    clearing,
   input  wire logic                               cmd_valid,
   output logic                                    cmd_ready,
   input  wire opcq_pkg::cmd_type                  cmd,
   input  wire logic [3*MAX_DEPTH-1:0]             cmd_addr,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [opcq_pkg::CH_W-1:0]               rsp_out_red,
   output logic [opcq_pkg::CH_W-1:0]               rsp_out_green,
   output logic [opcq_pkg::CH_W-1:0]               rsp_out_blue,
   output logic                                    rsp_hit,
   output logic [opcq_pkg::COUNT_W-1:0]            rsp_entry_count
);

   localparam int AW      = 3 * MAX_DEPTH;
   localparam int ENTRIES = 1 << AW;
   localparam int CW      = AW + 1;
   localparam int KW      = (CW > opcq_pkg::INDEX_W) ? CW : opcq_pkg::INDEX_W;
   localparam int XW      = (CW > opcq_pkg::COUNT_W) ? CW : opcq_pkg::COUNT_W;

   // tables
   logic                          valid_mem [ENTRIES];
   logic [opcq_pkg::COLOR_W-1:0]  color_mem [ENTRIES];
   logic [AW-1:0]                 order_mem [ENTRIES];

   opcq_pkg::back_state_type      state_ff;
   opcq_pkg::back_state_type      state_in;
   opcq_pkg::cmd_type             cur_ff;
   opcq_pkg::cmd_type             cur_in;
   logic [AW-1:0]                 addr_ff;
   logic [AW-1:0]                 addr_in;
   logic [AW-1:0]                 clr_ff;
   logic [AW-1:0]                 clr_in;
   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 count_in;

   logic                          vrd_ff;
   logic [opcq_pkg::COLOR_W-1:0]  crd_ff;
   logic [AW-1:0]                 ord_ff;

   logic                          v_we;
   logic [AW-1:0]                 v_waddr;
   logic                          v_wdata;
   logic                          c_we;
   logic                          o_we;
   logic                          vc_re;
   logic                          c_re;
   logic [AW-1:0]                 c_raddr;
   logic                          o_re;
   logic [AW+opcq_pkg::INDEX_W-1:0] k_wide;
   logic [AW-1:0]                 o_raddr;
   logic                          k_in_range;
   logic [XW-1:0]                 cnt_wide;

   logic                          slot_free;
   logic                          res_load;
   logic [opcq_pkg::COLOR_W-1:0]  res_color;
   logic                          res_hit;
   logic [opcq_pkg::COUNT_W-1:0]  res_count;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [opcq_pkg::COLOR_W-1:0]  rsp_color_ff;
   logic                          rsp_hit_ff;
   logic [opcq_pkg::COUNT_W-1:0]  rsp_count_ff;

   assign k_wide     = {{AW{1'b0}}, cmd.palette_index};
   assign o_raddr    = k_wide[AW-1:0];
   assign k_in_range = KW'(cmd.palette_index) < KW'(count_ff);
   assign cnt_wide   = XW'(count_in);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign clearing   = (state_ff == opcq_pkg::ST_CLEAR);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      addr_in   = addr_ff;
      clr_in    = clr_ff;
      count_in  = count_ff;
      cmd_ready = 1'b0;
      v_we      = 1'b0;
      v_waddr   = addr_ff;
      v_wdata   = 1'b1;
      c_we      = 1'b0;
      o_we      = 1'b0;
      vc_re     = 1'b0;
      c_re      = 1'b0;
      c_raddr   = cmd_addr;
      o_re      = 1'b0;
      res_load  = 1'b0;
      res_color = opcq_pkg::COLOR_BLACK;
      res_hit   = 1'b0;
      unique case (state_ff)
         opcq_pkg::ST_CLEAR: begin
            v_we    = 1'b1;
            v_waddr = clr_ff;
            v_wdata = 1'b0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == '1) begin
               state_in = opcq_pkg::ST_IDLE;
            end
         end
         opcq_pkg::ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cur_in  = cmd;
               addr_in = cmd_addr;
               unique case (cmd.kind)
                  opcq_pkg::OP_INSERT, opcq_pkg::OP_MAP: begin
                     vc_re    = 1'b1;
                     c_re     = 1'b1;
                     state_in = opcq_pkg::ST_LOOK;
                  end
                  opcq_pkg::OP_PALETTE: begin
                     if (k_in_range) begin
                        o_re     = 1'b1;
                        state_in = opcq_pkg::ST_ORDER;
                     end else begin
                        state_in = opcq_pkg::ST_EMIT;
                     end
                  end
                  opcq_pkg::OP_DIRECT: begin
                     state_in = opcq_pkg::ST_EMIT;
                  end
               endcase
            end
         end
         opcq_pkg::ST_LOOK: begin
            if (slot_free) begin
               res_load = 1'b1;
               res_hit  = vrd_ff;
               state_in = opcq_pkg::ST_IDLE;
               if (cur_ff.kind == opcq_pkg::OP_INSERT) begin
                  // mark, store, and append a new node to the creation list
                  v_we = 1'b1;
                  c_we = 1'b1;
                  if (!vrd_ff && !count_ff[AW]) begin
                     o_we     = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end else if (vrd_ff) begin
                  res_color = crd_ff;
               end
            end
         end
         opcq_pkg::ST_ORDER: begin
            c_re     = 1'b1;
            c_raddr  = ord_ff;
            state_in = opcq_pkg::ST_FETCH;
         end
         opcq_pkg::ST_FETCH: begin
            if (slot_free) begin
               res_load  = 1'b1;
               res_color = crd_ff;
               res_hit   = 1'b1;
               state_in  = opcq_pkg::ST_IDLE;
            end
         end
         opcq_pkg::ST_EMIT: begin
            if (slot_free) begin
               res_load = 1'b1;
               state_in = opcq_pkg::ST_IDLE;
               if (cur_ff.kind == opcq_pkg::OP_DIRECT) begin
                  res_color = cur_ff.color;
                  res_hit   = cur_ff.hit_fixed;
               end
            end
         end
         default: begin
            state_in = opcq_pkg::ST_CLEAR;
         end
      endcase
      // depth change restarts the sweep
      if (clear_start) begin
         state_in = opcq_pkg::ST_CLEAR;
         clr_in   = '0;
         count_in = '0;
      end
   end

   // reported count, fixed at the black and white level
   always_comb begin
      res_count = cnt_wide[opcq_pkg::COUNT_W-1:0];
      if (cur_ff.count_fixed) begin
         res_count = opcq_pkg::BW_COUNT;
      end
   end

   assign rsp_valid_in = res_load || (rsp_valid_ff && !rsp_ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= opcq_pkg::ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      addr_ff <= addr_in;
      if (res_load) begin
         rsp_color_ff <= res_color;
         rsp_hit_ff   <= res_hit;
         rsp_count_ff <= res_count;
      end
   end

   // valid store
   always_ff @(posedge clock) begin
      if (v_we) begin
         valid_mem[v_waddr] <= v_wdata;
      end
      if (vc_re) begin
         vrd_ff <= valid_mem[cmd_addr];
      end
   end

   // colour store
   always_ff @(posedge clock) begin
      if (c_we) begin
         color_mem[addr_ff] <= cur_ff.color;
      end
      if (c_re) begin
         crd_ff <= color_mem[c_raddr];
      end
   end

   // creation order list
   always_ff @(posedge clock) begin
      if (o_we) begin
         order_mem[count_ff[AW-1:0]] <= addr_ff;
      end
      if (o_re) begin
         ord_ff <= order_mem[o_raddr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_red     = rsp_color_ff[3*opcq_pkg::CH_W-1:2*opcq_pkg::CH_W];
   assign rsp_out_green   = rsp_color_ff[2*opcq_pkg::CH_W-1:opcq_pkg::CH_W];
   assign rsp_out_blue    = rsp_color_ff[opcq_pkg::CH_W-1:0];
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

`default_nettype wire

// ===== sv/opcq_checker.sv =====
`default_nettype none

module opcq_checker #(
   parameter int MAX_DEPTH = 4
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             csr_wr_en,
   input wire logic [opcq_pkg::DEPTH_REG_W-1:0] csr_wr_data,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic [1:0]                       req_mode,
   input wire logic [opcq_pkg::CH_W-1:0]        req_red,
   input wire logic [opcq_pkg::CH_W-1:0]        req_green,
   input wire logic [opcq_pkg::CH_W-1:0]        req_blue,
   input wire logic [opcq_pkg::INDEX_W-1:0]     req_palette_index,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [opcq_pkg::CH_W-1:0]        rsp_out_red,
   input wire logic [opcq_pkg::CH_W-1:0]        rsp_out_green,
   input wire logic [opcq_pkg::CH_W-1:0]        rsp_out_blue,
   input wire logic                             rsp_hit,
   input wire logic [opcq_pkg::COUNT_W-1:0]     rsp_entry_count
);

   logic [opcq_pkg::COLOR_W-1:0] rsp_color;

   assign rsp_color = {rsp_out_red, rsp_out_green, rsp_out_blue};

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // a stalled result word keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_color) && $stable(rsp_hit)
                                   && $stable(rsp_entry_count))
      else $error("result payload changed while stalled");

   // no word taken right after reset, the valid store is being swept
   a_sweep_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("word taken before valid store sweep");

   // a depth write starts a sweep
   a_sweep_after_depth: assert property (@(posedge clock)
      csr_wr_en |=> !req_ready)
      else $error("word taken right after depth write");

   // a miss or a fresh insert reports black
   a_miss_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_color == opcq_pkg::COLOR_BLACK)
      else $error("miss with non-black colour");

endmodule

bind octree_prefix_color_quantizer opcq_checker #(.MAX_DEPTH(MAX_DEPTH)) u_opcq_checker (.*);

`default_nettype wire

// ===== verif/octree_prefix_color_quantizer_test.sv =====
`default_nettype none

module octree_prefix_color_quantizer_test;

   localparam int TREE_LEVELS   = 4;
   localparam int NODE_COUNT    = 1 << (3 * TREE_LEVELS);
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 400;
   localparam int TIMEOUT_TICKS = 20_000_000;

   // the one mode code the block leaves unused
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // one result word
   typedef struct packed {
      logic [opcq_pkg::CH_W-1:0]    red;
      logic [opcq_pkg::CH_W-1:0]    green;
      logic [opcq_pkg::CH_W-1:0]    blue;
      logic                         hit;
      logic [opcq_pkg::COUNT_W-1:0] count;
   } color_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_wr_en = 1'b0;
   logic [opcq_pkg::DEPTH_REG_W-1:0] csr_wr_data = '0;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [1:0]                       req_mode = opcq_pkg::MODE_INSERT;
   logic [opcq_pkg::CH_W-1:0]        req_red = '0;
   logic [opcq_pkg::CH_W-1:0]        req_green = '0;
   logic [opcq_pkg::CH_W-1:0]        req_blue = '0;
   logic [opcq_pkg::INDEX_W-1:0]     req_palette_index = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [opcq_pkg::CH_W-1:0]        rsp_out_red;
   logic [opcq_pkg::CH_W-1:0]        rsp_out_green;
   logic [opcq_pkg::CH_W-1:0]        rsp_out_blue;
   logic                             rsp_hit;
   logic [opcq_pkg::COUNT_W-1:0]     rsp_entry_count;

   // shadow of the quantizer state
   logic [opcq_pkg::COLOR_W-1:0]     node_color [NODE_COUNT];
   bit                               node_used  [NODE_COUNT];
   logic [opcq_pkg::INDEX_W-1:0]     order_list [NODE_COUNT];
   int unsigned                      node_total = 0;
   logic [opcq_pkg::DEPTH_REG_W-1:0] tree_depth = opcq_pkg::DEPTH_REG_W'(TREE_LEVELS);

   color_result_type                 expected_colors [$];
   int                               error_count = 0;
   int                               idle_pct = 0;
   int                               stall_pct = 0;
   logic                             hold_flip = 1'b0;
   logic                             hold_seen = 1'b0;
   int                               hold_left = 0;

   octree_prefix_color_quantizer #(
      .MAX_DEPTH(TREE_LEVELS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .req_palette_index(req_palette_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_red(rsp_out_red),
      .rsp_out_green(rsp_out_green),
      .rsp_out_blue(rsp_out_blue),
      .rsp_hit(rsp_hit),
      .rsp_entry_count(rsp_entry_count)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // random field values at their own widths
   function automatic logic [opcq_pkg::CH_W-1:0] rand_channel();
      return opcq_pkg::CH_W'($urandom());
   endfunction

   function automatic logic [opcq_pkg::INDEX_W-1:0] rand_index();
      return opcq_pkg::INDEX_W'($urandom());
   endfunction

   function automatic logic [opcq_pkg::COLOR_W-1:0] rand_pixel();
      return opcq_pkg::COLOR_W'($urandom());
   endfunction

   // tree level in use, register values above the top level saturate
   function automatic int unsigned used_levels();
      return (tree_depth > TREE_LEVELS) ? TREE_LEVELS : tree_depth;
   endfunction

   // node address: top bits of red, green, blue interleaved from the msb down
   function automatic logic [opcq_pkg::INDEX_W-1:0] node_of(
         input logic [opcq_pkg::CH_W-1:0] r, g, b, input int unsigned levels);
      logic [opcq_pkg::INDEX_W-1:0] addr;
      addr = '0;
      for (int i = 0; i < levels; i++) begin
         addr = {addr[opcq_pkg::INDEX_W-4:0], r[opcq_pkg::CH_W-1-i], g[opcq_pkg::CH_W-1-i],
                 b[opcq_pkg::CH_W-1-i]};
      end
      return addr;
   endfunction

   // expected result of one word, updating the shadow state
   task automatic quantize_word(input logic [1:0] mode,
                                input logic [opcq_pkg::CH_W-1:0] r, g, b,
                                input logic [opcq_pkg::INDEX_W-1:0] k,
                                output color_result_type res);
      int unsigned                  levels;
      logic [opcq_pkg::INDEX_W-1:0] addr;
      logic [opcq_pkg::COLOR_W-1:0] colour;
      logic                         found;
      logic [opcq_pkg::COUNT_W-1:0] total;
      levels = used_levels();
      colour = opcq_pkg::COLOR_BLACK;
      found = 1'b0;
      if (levels == 0) begin
         // fixed black and white quantizer
         case (mode)
            opcq_pkg::MODE_INSERT: found = 1'b1;
            opcq_pkg::MODE_MAP: begin
               found = 1'b1;
               if (r[opcq_pkg::CH_W-1] | g[opcq_pkg::CH_W-1] | b[opcq_pkg::CH_W-1])
                  colour = opcq_pkg::COLOR_WHITE;
            end
            opcq_pkg::MODE_PALETTE: begin
               if (k == opcq_pkg::PAL_WHITE_IDX) begin
                  colour = opcq_pkg::COLOR_WHITE;
                  found = 1'b1;
               end else if (k == opcq_pkg::PAL_BLACK_IDX) begin
                  found = 1'b1;
               end
            end
            default: ;
         endcase
         total = opcq_pkg::BW_COUNT;
      end else begin
         case (mode)
            opcq_pkg::MODE_INSERT: begin
               addr = node_of(r, g, b, levels);
               found = node_used[addr];
               if (!found && node_total < NODE_COUNT) begin
                  order_list[node_total] = addr;
                  node_total++;
               end
               node_used[addr] = 1'b1;
               node_color[addr] = {r, g, b};
            end
            opcq_pkg::MODE_MAP: begin
               addr = node_of(r, g, b, levels);
               if (node_used[addr]) begin
                  colour = node_color[addr];
                  found = 1'b1;
               end
            end
            opcq_pkg::MODE_PALETTE: begin
               if (k < node_total) begin
                  colour = node_color[order_list[k]];
                  found = 1'b1;
               end
            end
            default: ;
         endcase
         total = opcq_pkg::COUNT_W'(node_total);
      end
      res.red = colour[23:16];
      res.green = colour[15:8];
      res.blue = colour[7:0];
      res.hit = found;
      res.count = total;
   endtask

   task automatic report_error(input string msg);
      $display("error at %0t: %s", $time, msg);
      error_count++;
   endtask

   // result side: compare each accepted word with the oldest prediction
   always @(posedge clock) begin : check_rsp
      color_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_colors.size() == 0) begin
            report_error("result word with nothing outstanding");
         end else begin
            want = expected_colors.pop_front();
            if (rsp_out_red !== want.red)
               report_error($sformatf("red: expected %0d, got %0d", want.red, rsp_out_red));
            if (rsp_out_green !== want.green)
               report_error($sformatf("green: expected %0d, got %0d",
                                      want.green, rsp_out_green));
            if (rsp_out_blue !== want.blue)
               report_error($sformatf("blue: expected %0d, got %0d", want.blue, rsp_out_blue));
            if (rsp_hit !== want.hit)
               report_error($sformatf("hit: expected %0d, got %0d", want.hit, rsp_hit));
            if (rsp_entry_count !== want.count)
               report_error($sformatf("entry_count: expected %0d, got %0d",
                                      want.count, rsp_entry_count));
         end
      end
   end

   // result side ready: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_flip != hold_seen) begin
         hold_seen <= hold_flip;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // offer one word, wait for it to be taken, then record its prediction
   task automatic send_word(input logic [1:0] mode, input logic [opcq_pkg::CH_W-1:0] r, g, b,
                            input logic [opcq_pkg::INDEX_W-1:0] k);
      color_result_type res;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      req_palette_index <= k;
      do @(posedge clock); while (!req_ready);
      quantize_word(mode, r, g, b, k, res);
      expected_colors.insert(expected_colors.size(), res);
   endtask

   // wait until every result is back and the block is quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // depth write clears the valid store and the creation count
   task automatic write_depth(input logic [opcq_pkg::DEPTH_REG_W-1:0] value);
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tree_depth = value;
      foreach (node_used[i]) node_used[i] = 1'b0;
      node_total = 0;
   endtask

   // pixel sharing the node prefix of base, with fresh low bits
   function automatic logic [opcq_pkg::COLOR_W-1:0] near_pixel(
         input logic [opcq_pkg::COLOR_W-1:0] base);
      logic [opcq_pkg::CH_W-1:0]    keep;
      logic [opcq_pkg::COLOR_W-1:0] fresh;
      keep = ~({opcq_pkg::CH_W{1'b1}} >> used_levels());
      fresh = rand_pixel();
      return (base & {3{keep}}) | (fresh & ~{3{keep}});
   endfunction

   // mostly around the live count, sometimes the whole index range
   function automatic logic [opcq_pkg::INDEX_W-1:0] pick_palette_index();
      int unsigned top;
      top = node_total + 2;
      if (top > NODE_COUNT - 1) top = NODE_COUNT - 1;
      if ($urandom_range(99) < 80) return opcq_pkg::INDEX_W'($urandom_range(top));
      return rand_index();
   endfunction

   task automatic send_palette_read();
      send_word(opcq_pkg::MODE_PALETTE, rand_channel(), rand_channel(), rand_channel(),
                pick_palette_index());
   endtask

   task automatic send_unused();
      send_word(MODE_UNUSED, rand_channel(), rand_channel(), rand_channel(), rand_index());
   endtask

   // one depth setting: training words first, then mapping words, palette and unused reads in both
   task automatic run_phase(input logic [opcq_pkg::DEPTH_REG_W-1:0] depth_val,
                            input int send_idle, input int recv_stall, input int words,
                            input bit with_hold);
      logic [opcq_pkg::COLOR_W-1:0] trained [$];
      logic [opcq_pkg::COLOR_W-1:0] px;
      int                           sel;
      int                           n_train;
      settle();
      write_depth(depth_val);
      idle_pct = send_idle;
      stall_pct <= recv_stall;
      n_train = words / 2;
      for (int i = 0; i < words; i++) begin
         sel = $urandom_range(99);
         if (with_hold && i == 12) hold_flip <= ~hold_flip;
         if (i < n_train) begin
            if (sel < 88) begin
               if (trained.size() != 0 && $urandom_range(99) < 30)
                  px = near_pixel(trained[$urandom_range(trained.size() - 1)]);
               else
                  px = rand_pixel();
               trained.insert(trained.size(), px);
               send_word(opcq_pkg::MODE_INSERT, px[23:16], px[15:8], px[7:0], rand_index());
            end else if (sel < 94) begin
               send_palette_read();
            end else begin
               send_unused();
            end
         end else begin
            if (sel < 70) begin
               if (trained.size() != 0 && $urandom_range(99) < 75)
                  px = near_pixel(trained[$urandom_range(trained.size() - 1)]);
               else
                  px = rand_pixel();
               send_word(opcq_pkg::MODE_MAP, px[23:16], px[15:8], px[7:0], rand_index());
            end else if (sel < 93) begin
               send_palette_read();
            end else begin
               send_unused();
            end
         end
      end
   endtask

   // empty table straight after reset
   task automatic test_empty_after_reset();
      send_word(opcq_pkg::MODE_MAP, 8'h80, 8'h00, 8'h00, '0);
      send_word(opcq_pkg::MODE_PALETTE, 8'h00, 8'h00, 8'h00, opcq_pkg::PAL_WHITE_IDX);
      send_word(opcq_pkg::MODE_PALETTE, 8'h00, 8'h00, 8'h00, {opcq_pkg::INDEX_W{1'b1}});
      send_word(MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF, {opcq_pkg::INDEX_W{1'b1}});
   endtask

   // inserts, repeat node with last writer winning, hits and misses
   task automatic test_insert_and_map();
      send_word(opcq_pkg::MODE_INSERT, 8'h00, 8'h00, 8'h00, '0);
      send_word(opcq_pkg::MODE_INSERT, 8'hFF, 8'hFF, 8'hFF, {opcq_pkg::INDEX_W{1'b1}});
      send_word(opcq_pkg::MODE_INSERT, 8'h0F, 8'h0F, 8'h0F, '0);
      send_word(opcq_pkg::MODE_MAP, 8'h05, 8'h0A, 8'h03, '0);
      send_word(opcq_pkg::MODE_MAP, 8'hFF, 8'hF0, 8'hF8, '0);
      send_word(opcq_pkg::MODE_MAP, 8'h80, 8'h00, 8'h00, '0);
      send_word(opcq_pkg::MODE_PALETTE, 8'h00, 8'h00, 8'h00, 12'd1);
      send_word(opcq_pkg::MODE_PALETTE, 8'h00, 8'h00, 8'h00, 12'd2);
   endtask

   // depth zero: fixed black and white behaviour
   task automatic test_black_and_white();
      settle();
      write_depth(3'd0);
      send_word(opcq_pkg::MODE_INSERT, 8'hFF, 8'hFF, 8'hFF, '0);
      send_word(opcq_pkg::MODE_MAP, 8'h7F, 8'h7F, 8'h7F, '0);
      send_word(opcq_pkg::MODE_MAP, 8'h00, 8'h00, 8'h80, '0);
      send_word(opcq_pkg::MODE_MAP, 8'h00, 8'h80, 8'h00, '0);
      send_word(opcq_pkg::MODE_PALETTE, 8'h00, 8'h00, 8'h00, opcq_pkg::PAL_WHITE_IDX);
      send_word(opcq_pkg::MODE_PALETTE, 8'h00, 8'h00, 8'h00, opcq_pkg::PAL_BLACK_IDX);
      send_word(opcq_pkg::MODE_PALETTE, 8'h00, 8'h00, 8'h00, 12'd2);
   endtask

   // register value above the top level behaves as the top level
   task automatic test_depth_saturation();
      settle();
      write_depth(3'd7);
      send_word(opcq_pkg::MODE_INSERT, 8'h12, 8'h34, 8'h56, '0);
      send_word(opcq_pkg::MODE_INSERT, 8'h1F, 8'h3F, 8'h5F, '0);
      send_word(opcq_pkg::MODE_PALETTE, 8'h00, 8'h00, 8'h00, opcq_pkg::PAL_WHITE_IDX);
      send_word(opcq_pkg::MODE_MAP, 8'h10, 8'h30, 8'h50, '0);
   endtask

   // random training and mapping over depth values 0 to 6 and several idling and stall mixes
   task automatic test_random_training_and_mapping();
      run_phase(3'd4, 0, 0, 300, 1'b0);
      run_phase(3'd1, 55, 0, 150, 1'b0);
      run_phase(3'd2, 0, 55, 300, 1'b0);
      run_phase(3'd3, 18, 18, 300, 1'b0);
      run_phase(3'd5, 0, 0, 200, 1'b0);
      run_phase(3'd0, 55, 55, 120, 1'b0);
      run_phase(3'd2, 18, 18, 200, 1'b0);
      run_phase(3'd6, 0, 0, 100, 1'b0);
   endtask

   // long receiver hold-off so the queue fills and the input stalls
   task automatic test_output_backpressure();
      run_phase(3'd4, 0, 0, 300, 1'b1);
   endtask

   // main sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_after_reset();
      test_insert_and_map();
      test_black_and_white();
      test_depth_saturation();
      test_random_training_and_mapping();
      test_output_backpressure();
      settle();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_TICKS);
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
